FILE: rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLKD(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/gmm_pkg.sv
// ----------------------------------------------------------------------------
// gmm_pkg
// types and constants of the greedy maximal matching core
// ----------------------------------------------------------------------------
package gmm_pkg;

    localparam int GMM_VERTEX_COUNT = 1024;
    localparam int VW               = 10;
    localparam int CW               = 11;

    localparam logic [CW-1:0] COUNT_MAX = '1;

    // item kinds
    localparam logic [1:0] KIND_EDGE  = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]    kind;
        logic [VW-1:0] vertex_u;
        logic [VW-1:0] vertex_v;
        logic          last_edge;
    } t_gmm_in;

    typedef struct packed {
        logic          edge_taken;
        logic          partner_valid;
        logic [VW-1:0] partner;
        logic [CW-1:0] match_count;
        logic          final_res;
    } t_gmm_out;

    // one partner store entry
    typedef struct packed {
        logic          matched;
        logic [VW-1:0] partner;
    } t_entry;

endpackage

FILE: rtl/greedy_maximal_matching_core.sv
// ----------------------------------------------------------------------------
// greedy_maximal_matching_core
// greedy maximal matching over a stream of edges, partner store in a memory
// ----------------------------------------------------------------------------
//
//  channel   handshake       payload             direction
//  -------   -------------   -----------------   ---------
//  item      start / busy    i_item (t_gmm_in)   in
//  result    o_done strobe   o_result (t_gmm_out) out
//
//  an edge or query is read, then evaluated: the accept edge issues both store reads,
//  then S_EVAL evaluates the registered read data and registers the result
//  a taken edge with two distinct endpoints adds state S_WRV for the second
//  write, since the store has a single write port
//  a clear item sweeps the store one entry a cycle in state S_CLR
//  after reset the same sweep runs, and busy stays high until it ends
//  the result shows for one cycle after evaluation; the receiver cannot stall
//
module greedy_maximal_matching_core #(
    parameter int VERTEX_COUNT = gmm_pkg::GMM_VERTEX_COUNT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  gmm_pkg::t_gmm_in  i_item,
    output logic              o_done,
    output gmm_pkg::t_gmm_out o_result
);
    import gmm_pkg::*;

    `include "assert_macros.svh"

    localparam int AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_WRV  = 4'b0100,
        S_CLR  = 4'b1000
    } t_state;

    // partner store, one read per endpoint, one write port
    t_entry mem [VERTEX_COUNT];

    t_state   r_state,    n_state;
    t_gmm_in  r_item;
    t_entry   r_rd_u,     r_rd_v;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic     r_done,     n_done;
    t_gmm_out r_result,   n_result;

    logic          w_en;
    logic [AW-1:0] w_addr;
    t_entry        w_data;
    logic          u_in, v_in, edge_ok;
    logic          accept;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // vertices at or above the store depth have no entry
    assign u_in    = (32'(r_item.vertex_u) < 32'(VERTEX_COUNT));
    assign v_in    = (32'(r_item.vertex_v) < 32'(VERTEX_COUNT));
    assign edge_ok = u_in && v_in && !r_rd_u.matched && !r_rd_v.matched;

    // store access: reads issued at accept, data registered
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        if (accept) begin
            r_rd_u <= mem[AW'(i_item.vertex_u)];
            r_rd_v <= mem[AW'(i_item.vertex_v)];
            r_item <= i_item;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_clr_addr = r_clr_addr;
        n_done     = 1'b0;
        n_result   = '0;
        w_en       = 1'b0;
        w_addr     = '0;
        w_data     = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
                case (r_item.kind)
                    KIND_EDGE: begin
                        n_result.final_res = r_item.last_edge;
                        if (edge_ok) begin
                            n_result.edge_taken = 1'b1;
                            n_count = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;
                            w_en           = 1'b1;
                            w_addr         = AW'(r_item.vertex_u);
                            w_data.matched = 1'b1;
                            w_data.partner = r_item.vertex_v;
                            // self-loop needs only the one write
                            if (r_item.vertex_u != r_item.vertex_v) begin
                                n_state = S_WRV;
                            end
                        end
                    end
                    KIND_QUERY: begin
                        if (u_in && r_rd_u.matched) begin
                            n_result.partner_valid = 1'b1;
                            n_result.partner       = r_rd_u.partner;
                        end
                    end
                    KIND_CLEAR: begin
                        n_count    = '0;
                        n_clr_addr = '0;
                        n_state    = S_CLR;
                    end
                    default: begin
                    end
                endcase
                n_result.match_count = n_count;
            end
            S_WRV: begin
                // second endpoint of a taken edge
                w_en           = 1'b1;
                w_addr         = AW'(r_item.vertex_v);
                w_data.matched = 1'b1;
                w_data.partner = r_item.vertex_u;
                n_state        = S_IDLE;
            end
            S_CLR: begin
                w_en   = 1'b1;
                w_addr = r_clr_addr;
                w_data = '0;
                if (r_clr_addr == AW'(VERTEX_COUNT - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_addr <= '0;
            r_count    <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_count    <= n_count;
            r_done     <= n_done;
        end
    end

    // result register, payload needs no reset
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    `ASSERT_CLKD(a_done_single, o_done |=> !o_done, "result strobe held two cycles")
    `ASSERT_CLKD(a_accept_eval, accept |=> (r_state == S_EVAL), "accepted item not evaluated")
    `ASSERT_ALWAYS(a_clr_count, (r_state == S_CLR) |-> (r_count == '0), "count nonzero in clear")
    `ASSERT_CLKD(a_wrv_after_eval, (r_state == S_WRV) |-> $past(r_state == S_EVAL),
        "second write without taken edge")

endmodule

FILE: sim/greedy_maximal_matching_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// greedy_maximal_matching_core_tb
// self-checking bench for the greedy maximal matching core
//
// drives edge, query, clear and unused-kind items through the start / busy
// handshake, predicts every result from a private copy of the partner store
// and checks each strobed result against the oldest prediction
// ----------------------------------------------------------------------------
module greedy_maximal_matching_core_tb;

    import gmm_pkg::*;

    // the one kind the package leaves without a name; the core must ignore it
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int QUIET_ITEMS   = 200;   // closing stretch with no idling
    localparam int TAIL_CYCLES   = 8;
    localparam int CYCLE_LIMIT   = 6000000;
    localparam int MAX_REPORTS   = 40;

    // ------------------------------------------------------------------------
    // scoreboard: owns the predicted matching and the queue of results due
    // ------------------------------------------------------------------------
    class matching_scoreboard;
        bit            is_matched [GMM_VERTEX_COUNT];
        logic [VW-1:0] mate       [GMM_VERTEX_COUNT];
        logic [CW-1:0] edges_taken;
        t_gmm_out      results_due [$];
        int            errors;

        function new();
            forget_matching();
            errors = 0;
        endfunction

        function void forget_matching();
            foreach (is_matched[i]) begin
                is_matched[i] = 1'b0;
                mate[i]       = '0;
            end
            edges_taken = '0;
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        // one accepted transfer in, one predicted result queued
        function void note_item(t_gmm_in it);
            t_gmm_out r;
            int       u;
            int       v;
            r = '0;
            u = int'(it.vertex_u);
            v = int'(it.vertex_v);
            case (it.kind)
                KIND_EDGE: begin
                    r.final_res = it.last_edge;
                    if (u < GMM_VERTEX_COUNT && v < GMM_VERTEX_COUNT &&
                        !is_matched[u] && !is_matched[v]) begin
                        is_matched[u] = 1'b1;
                        mate[u]       = it.vertex_v;
                        is_matched[v] = 1'b1;
                        mate[v]       = it.vertex_u;
                        if (edges_taken != COUNT_MAX)
                            edges_taken++;
                        r.edge_taken = 1'b1;
                    end
                end
                KIND_QUERY: begin
                    if (u < GMM_VERTEX_COUNT && is_matched[u]) begin
                        r.partner_valid = 1'b1;
                        r.partner       = mate[u];
                    end
                end
                KIND_CLEAR: forget_matching();
                default: ;
            endcase
            r.match_count = edges_taken;
            results_due.push_back(r);
        endfunction

        function void flag(string what, logic [CW-1:0] want, logic [CW-1:0] got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: mismatch on %s, expected %0d, actual %0d",
                         $time, what, want, got);
        endfunction

        function void check_result(t_gmm_out got);
            t_gmm_out want;
            if (results_due.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result with nothing expected, expected none, actual %h",
                             $time, got);
                return;
            end
            want = results_due.pop_front();
            if (got.edge_taken !== want.edge_taken)
                flag("edge_taken", CW'(want.edge_taken), CW'(got.edge_taken));
            if (got.partner_valid !== want.partner_valid)
                flag("partner_valid", CW'(want.partner_valid), CW'(got.partner_valid));
            if (got.partner !== want.partner)
                flag("partner", CW'(want.partner), CW'(got.partner));
            if (got.match_count !== want.match_count)
                flag("match_count", want.match_count, got.match_count);
            if (got.final_res !== want.final_res)
                flag("final_res", CW'(want.final_res), CW'(got.final_res));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block under test
    // ------------------------------------------------------------------------
    logic     i_clk    = 1'b0;
    logic     i_rst_n  = 1'b0;
    logic     start    = 1'b0;
    logic     busy;
    t_gmm_in  i_item   = '0;
    logic     o_done;
    t_gmm_out o_result;

    greedy_maximal_matching_core i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    matching_scoreboard sb;

    // vertices touched by recent edges, so queries mostly hit matched entries
    int unsigned touched_vertices [$];
    int unsigned window_base = 0;
    int unsigned window_span = 32;
    int          cycle_count = 0;

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // watchdog, sized far above the slowest legal run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // the receiver cannot stall, so every strobe is a transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1)
            sb.check_result(o_result);
    end

    // ------------------------------------------------------------------------
    // driving tasks; every call returns just after a rising edge
    // ------------------------------------------------------------------------

    // hold start until the core takes the item
    task automatic send_item(t_gmm_in it);
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        sb.note_item(it);
    endtask

    task automatic pause_sender(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // sender holds off until every predicted result has been seen
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    function automatic t_gmm_in make_item(logic [1:0] kind, int unsigned u,
                                          int unsigned v, int unsigned last);
        t_gmm_in it;
        it.kind      = kind;
        it.vertex_u  = u[VW-1:0];
        it.vertex_v  = v[VW-1:0];
        it.last_edge = last[0];
        return it;
    endfunction

    // mostly a crowded window so edges collide, sometimes anywhere or an end
    function automatic int unsigned pick_vertex();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return (window_base + $urandom_range(0, window_span - 1)) % GMM_VERTEX_COUNT;
        else if (r < 9)
            return $urandom_range(0, GMM_VERTEX_COUNT - 1);
        else
            return ($urandom_range(0, 1) != 0) ? GMM_VERTEX_COUNT - 1 : 0;
    endfunction

    function automatic t_gmm_in random_item();
        int unsigned pick;
        int unsigned u;
        int unsigned v;
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
            // new graph: move the crowded window as well
            window_base = $urandom_range(0, GMM_VERTEX_COUNT - 1);
            window_span = $urandom_range(8, 64);
            touched_vertices.delete();
            return make_item(KIND_CLEAR, $urandom, $urandom, $urandom_range(0, 1));
        end else if (pick < 6) begin
            return make_item(KIND_UNUSED, $urandom, $urandom, $urandom_range(0, 1));
        end else if (pick < 38) begin
            if (touched_vertices.size() != 0 && $urandom_range(0, 9) < 7)
                u = touched_vertices[$urandom_range(0, touched_vertices.size() - 1)];
            else
                u = pick_vertex();
            // ignored fields still get random values
            return make_item(KIND_QUERY, u, $urandom, $urandom_range(0, 1));
        end else begin
            u = pick_vertex();
            v = ($urandom_range(0, 9) == 0) ? u : pick_vertex();
            touched_vertices.push_back(u);
            touched_vertices.push_back(v);
            while (touched_vertices.size() > 64)
                void'(touched_vertices.pop_front());
            return make_item(KIND_EDGE, u, v, ($urandom_range(0, 15) == 0) ? 1 : 0);
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        bit idle_on;

        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // the post-reset sweep shows up as busy; send_item waits it out

        // directed: both vertex extremes, every kind, self-loop, blocked edges
        send_item(make_item(KIND_QUERY, 0, 1023, 1));       // unmatched after reset
        send_item(make_item(KIND_EDGE, 0, 1023, 0));        // taken
        send_item(make_item(KIND_EDGE, 0, 5, 0));           // u already matched
        send_item(make_item(KIND_EDGE, 6, 1023, 0));        // v already matched
        send_item(make_item(KIND_EDGE, 7, 7, 0));           // self-loop taken
        send_item(make_item(KIND_EDGE, 7, 7, 0));           // self-loop now blocked
        send_item(make_item(KIND_EDGE, 5, 6, 0));           // back to back writes
        send_item(make_item(KIND_QUERY, 6, 0, 0));          // reads the write just done
        send_item(make_item(KIND_QUERY, 0, 0, 0));
        send_item(make_item(KIND_QUERY, 1023, 1023, 1));    // ignored fields set
        send_item(make_item(KIND_QUERY, 7, 0, 0));          // partner is itself
        send_item(make_item(KIND_QUERY, 3, 0, 0));          // never matched
        send_item(make_item(KIND_EDGE, 511, 512, 1));       // last edge of a graph
        send_item(make_item(KIND_UNUSED, 1023, 1023, 1));   // changes nothing
        send_item(make_item(KIND_UNUSED, 0, 0, 0));
        send_item(make_item(KIND_QUERY, 512, 0, 0));
        send_item(make_item(KIND_CLEAR, 1023, 1023, 1));    // clear with all fields set
        send_item(make_item(KIND_QUERY, 0, 0, 0));          // unmatched again
        send_item(make_item(KIND_QUERY, 7, 0, 0));
        send_item(make_item(KIND_EDGE, 1023, 0, 1));        // taken again after clear
        send_item(make_item(KIND_QUERY, 1023, 0, 0));
        send_item(make_item(KIND_CLEAR, 0, 0, 0));
        send_item(make_item(KIND_EDGE, 1, 1022, 0));

        // let the whole pipe empty before the random part
        wait_for_results();

        idle_on = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // switch at random between stretches with and without sender gaps
            if (n % 100 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            if (n % 400 == 250 && n < RANDOM_ITEMS - QUIET_ITEMS)
                wait_for_results();
            else if (idle_on && n < RANDOM_ITEMS - QUIET_ITEMS &&
                     $urandom_range(0, 9) < 3)
                pause_sender($urandom_range(1, 14));
            send_item(random_item());
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: greedy_maximal_matching_core.f
+incdir+rtl
rtl/gmm_pkg.sv
rtl/greedy_maximal_matching_core.sv
sim/greedy_maximal_matching_core_tb.sv
